/* hw/rtl/rsn_pkg.sv */
// Shared types, widths and constants of the ray/sphere nearest-hit block.
// No dependencies; used by every other file of the block except rsn_ram.
package rsn_pkg;

    localparam int COORD_W = 32;               // Q16.16 port fields
    localparam int CO_W    = COORD_W + 1;      // origin minus center
    localparam int H_W     = 66;               // CO.D
    localparam int K_W     = 67;               // CO.CO - r*r
    localparam int DEN_W   = 64;               // D.D, always >= 0
    localparam int MUL_W   = 68;               // signed multiplier operand
    localparam int PROD_W  = 136;              // signed product / discriminant
    localparam int DIG_W   = 16;               // multiplier digit per cycle
    localparam int NUM_DIG = (MUL_W + DIG_W - 1) / DIG_W;
    localparam int ROOT_W  = PROD_W / 2;       // floor(sqrt) width
    localparam int REM_W   = ROOT_W + 2;       // sqrt remainder
    localparam int NUM_W   = 70;               // -H +/- S
    localparam int T_W     = 35;               // saturated root, signed
    localparam int SAT_BIT = 33;               // roots clamp to +/-2^33

    localparam logic signed [T_W-1:0] T_UNBOUNDED = 35'sh080000000;  // 2^31
    localparam logic [SAT_BIT:0]      T_SAT_MAG   = 34'h200000000;   // 2^33
    localparam logic [COORD_W-1:0]    T_NOHIT_UNB = 32'h7FFFFFFF;

    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_CAST  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MU_GO,
        ST_MU_WT,
        ST_RD,
        ST_CO,
        ST_SQ_GO,
        ST_SQ_WT,
        ST_DV_GO,
        ST_DV_WT,
        ST_DONE
    } t_state;

    // multiply program: A once per ray, then H, K and Q per sphere
    typedef enum logic [3:0] {
        MS_A_DX, MS_A_DY, MS_A_DZ,
        MS_H_X,  MS_H_Y,  MS_H_Z,
        MS_K_X,  MS_K_Y,  MS_K_Z, MS_K_R,
        MS_Q_HH, MS_Q_AK
    } t_mstep;

    typedef enum logic [3:0] {
        OPND_DX, OPND_DY, OPND_DZ,
        OPND_CX, OPND_CY, OPND_CZ,
        OPND_R,  OPND_A,  OPND_H, OPND_K
    } t_opnd;

    typedef enum logic [1:0] {ACC_SET, ACC_ADD, ACC_SUB} t_accop;
    typedef enum logic [2:0] {DST_NONE, DST_A, DST_H, DST_K, DST_Q} t_dst;
    typedef enum logic {IT_SQRT, IT_DIV} t_itmode;

    typedef struct packed {
        t_opnd  a_sel;
        t_opnd  b_sel;
        t_accop acc;
        t_dst   dst;
    } t_step;

    typedef struct packed {
        logic signed [COORD_W-1:0] rad;
        logic signed [COORD_W-1:0] cz;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cx;
    } t_sphere;

    function automatic t_step step_ctl(input t_mstep step);
        t_step s;
        s = '{a_sel: OPND_DX, b_sel: OPND_DX, acc: ACC_SET, dst: DST_NONE};
        unique case (step)
            MS_A_DX: s = '{a_sel: OPND_DX, b_sel: OPND_DX, acc: ACC_SET, dst: DST_NONE};
            MS_A_DY: s = '{a_sel: OPND_DY, b_sel: OPND_DY, acc: ACC_ADD, dst: DST_NONE};
            MS_A_DZ: s = '{a_sel: OPND_DZ, b_sel: OPND_DZ, acc: ACC_ADD, dst: DST_A};
            MS_H_X:  s = '{a_sel: OPND_CX, b_sel: OPND_DX, acc: ACC_SET, dst: DST_NONE};
            MS_H_Y:  s = '{a_sel: OPND_CY, b_sel: OPND_DY, acc: ACC_ADD, dst: DST_NONE};
            MS_H_Z:  s = '{a_sel: OPND_CZ, b_sel: OPND_DZ, acc: ACC_ADD, dst: DST_H};
            MS_K_X:  s = '{a_sel: OPND_CX, b_sel: OPND_CX, acc: ACC_SET, dst: DST_NONE};
            MS_K_Y:  s = '{a_sel: OPND_CY, b_sel: OPND_CY, acc: ACC_ADD, dst: DST_NONE};
            MS_K_Z:  s = '{a_sel: OPND_CZ, b_sel: OPND_CZ, acc: ACC_ADD, dst: DST_NONE};
            MS_K_R:  s = '{a_sel: OPND_R,  b_sel: OPND_R,  acc: ACC_SUB, dst: DST_K};
            MS_Q_HH: s = '{a_sel: OPND_H,  b_sel: OPND_H,  acc: ACC_SET, dst: DST_NONE};
            MS_Q_AK: s = '{a_sel: OPND_A,  b_sel: OPND_K,  acc: ACC_SUB, dst: DST_Q};
            default: ;
        endcase
        return s;
    endfunction

endpackage

/* hw/rtl/rsn_ram.sv */
// Generic single-write, single-read synchronous RAM, read data registered.
// No dependencies.
module rsn_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rsn_mul.sv */
// Iterative signed multiplier, one 16-bit digit of the second operand per cycle.
// Depends on rsn_pkg.
module rsn_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [rsn_pkg::MUL_W-1:0]   i_a,
    input  logic signed [rsn_pkg::MUL_W-1:0]   i_b,
    output logic                               o_done,
    output logic signed [rsn_pkg::PROD_W-1:0]  o_prod
);

    localparam int BW = rsn_pkg::NUM_DIG * rsn_pkg::DIG_W;
    localparam int CW = $clog2(rsn_pkg::NUM_DIG + 1);
    localparam int PW = rsn_pkg::MUL_W + rsn_pkg::DIG_W;

    logic                        r_run, n_run;
    logic                        r_fin, n_fin;
    logic                        r_done, n_done;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [rsn_pkg::MUL_W-1:0]   r_ma, n_ma;
    logic [BW-1:0]               r_mb, n_mb;
    logic [rsn_pkg::PROD_W-1:0]  r_acc, n_acc;
    logic [rsn_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic                        r_neg, n_neg;
    logic [PW-1:0]               pp;
    logic [rsn_pkg::MUL_W-1:0]   mag_a, mag_b;

    always_comb begin
        mag_a  = i_a[rsn_pkg::MUL_W-1] ? unsigned'(-i_a) : unsigned'(i_a);
        mag_b  = i_b[rsn_pkg::MUL_W-1] ? unsigned'(-i_b) : unsigned'(i_b);
        pp     = r_ma * r_mb[BW-1 -: rsn_pkg::DIG_W];
        n_run  = r_run;
        n_fin  = 1'b0;
        n_done = r_fin;
        n_cnt  = r_cnt;
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_acc  = r_acc;
        n_neg  = r_neg;
        n_prod = r_prod;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = CW'(rsn_pkg::NUM_DIG);
            n_ma  = mag_a;
            n_mb  = BW'(mag_b);
            n_acc = '0;
            n_neg = i_a[rsn_pkg::MUL_W-1] ^ i_b[rsn_pkg::MUL_W-1];
        end else if (r_run) begin
            n_acc = (r_acc << rsn_pkg::DIG_W) + rsn_pkg::PROD_W'(pp);
            n_mb  = r_mb << rsn_pkg::DIG_W;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_run = 1'b0;
                n_fin = 1'b1;
            end
        end
        if (r_fin) begin
            n_prod = r_neg ? -r_acc : r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_fin  <= n_fin;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_acc  <= n_acc;
        r_neg  <= n_neg;
        r_prod <= n_prod;
    end

    assign o_done = r_done;
    assign o_prod = signed'(r_prod);

endmodule

/* hw/rtl/rsn_sqdiv.sv */
// Bit-serial unit: floor square root (2 radicand bits per cycle) or
// unsigned restoring division (1 quotient bit per cycle). Depends on rsn_pkg.
module rsn_sqdiv #(
    parameter int DVW = 86
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  rsn_pkg::t_itmode                  i_mode,
    input  logic [rsn_pkg::PROD_W-1:0]        i_rad,
    input  logic [DVW-1:0]                    i_num,
    input  logic [rsn_pkg::DEN_W-1:0]         i_den,
    output logic                              o_done,
    output logic [rsn_pkg::ROOT_W-1:0]        o_root,
    output logic [DVW-1:0]                    o_quot
);

    localparam int NMAX = (DVW > rsn_pkg::ROOT_W) ? DVW : rsn_pkg::ROOT_W;
    localparam int CW   = $clog2(NMAX + 1);
    localparam int DW   = rsn_pkg::DEN_W;

    rsn_pkg::t_itmode              r_mode, n_mode;
    logic                          r_run, n_run;
    logic                          r_done, n_done;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [rsn_pkg::PROD_W-1:0]    r_x, n_x;
    logic [rsn_pkg::REM_W-1:0]     r_rem, n_rem;
    logic [rsn_pkg::ROOT_W-1:0]    r_root, n_root;
    logic [DVW-1:0]                r_num, n_num;
    logic [DW-1:0]                 r_drem, n_drem;
    logic [DW-1:0]                 r_den, n_den;
    logic [DVW-1:0]                r_quot, n_quot;
    logic [rsn_pkg::REM_W-1:0]     rem2, trial;
    logic [DW:0]                   rr;
    logic                          ge_s, ge_d;

    always_comb begin
        rem2   = {r_rem[rsn_pkg::REM_W-3:0], r_x[rsn_pkg::PROD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        ge_s   = (rem2 >= trial);
        rr     = {r_drem, r_num[DVW-1]};
        ge_d   = (rr >= {1'b0, r_den});
        n_mode = r_mode;
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        n_num  = r_num;
        n_drem = r_drem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_start) begin
            n_mode = i_mode;
            n_run  = 1'b1;
            n_cnt  = (i_mode == rsn_pkg::IT_SQRT) ? CW'(rsn_pkg::ROOT_W) : CW'(DVW);
            n_x    = i_rad;
            n_rem  = '0;
            n_root = '0;
            n_num  = i_num;
            n_drem = '0;
            n_den  = i_den;
            n_quot = '0;
        end else if (r_run) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
            unique case (r_mode)
                rsn_pkg::IT_SQRT: begin
                    n_rem  = ge_s ? (rem2 - trial) : rem2;
                    n_root = {r_root[rsn_pkg::ROOT_W-2:0], ge_s};
                    n_x    = r_x << 2;
                end
                rsn_pkg::IT_DIV: begin
                    n_drem = ge_d ? DW'(rr - {1'b0, r_den}) : DW'(rr);
                    n_quot = {r_quot[DVW-2:0], ge_d};
                    n_num  = r_num << 1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_cnt  <= n_cnt;
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_num  <= n_num;
        r_drem <= n_drem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_root = r_root;
    assign o_quot = r_quot;

endmodule

/* hw/rtl/ray_sphere_nearest_hit.sv */
// Ray against a table of spheres, nearest hit. Depends on rsn_pkg, rsn_ram,
// rsn_mul and rsn_sqdiv.
//
// Usage: a transfer happens when start is high and busy is low. A write
// (i_opcode 0) stores center i_point_* and radius i_dir_x into entry
// i_entry_index in that same cycle and never raises busy. A cast (i_opcode 1)
// raises busy and, when finished, puts one result on o_hit / o_hit_index /
// o_nearest_t for exactly one cycle with o_valid high; it must be taken then,
// there is no way to hold it. A cast's run time is set by the bit-serial
// square-root/divide unit (one quotient bit per cycle, up to two roots per sphere)
// and by the 68x16 digit multiplier that forms D.D, CO.D, CO.CO-r^2 and the
// discriminant. A ray with zero direction finishes right after D.D is formed.
// The sphere table is a RAM that is never cleared: casting against an entry
// that was never written gives undefined results. i_cfg_we writes the
// active_spheres register; write it only while the block is idle.
module ray_sphere_nearest_hit #(
    parameter int MAX_SPHERES = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic               i_opcode,
    input  logic [3:0]         i_entry_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic signed [31:0] i_near_bound,
    input  logic signed [31:0] i_far_bound,
    input  logic               i_far_unbounded,
    output logic               o_valid,
    output logic               o_hit,
    output logic [3:0]         o_hit_index,
    output logic signed [31:0] o_nearest_t
);

    localparam int IW  = $clog2(MAX_SPHERES > 1 ? MAX_SPHERES : 2);
    localparam int CW  = $clog2(MAX_SPHERES + 1);
    localparam int DVW = rsn_pkg::NUM_W + FRAC_BITS;
    localparam int SW  = $bits(rsn_pkg::t_sphere);

    localparam int XW  = rsn_pkg::COORD_W;
    localparam int MW  = rsn_pkg::MUL_W;
    localparam int PW  = rsn_pkg::PROD_W;
    localparam int TW  = rsn_pkg::T_W;
    localparam int NW  = rsn_pkg::NUM_W;

    // control
    rsn_pkg::t_state           r_state, n_state;
    rsn_pkg::t_mstep           r_step, n_step;
    logic [4:0]                r_active;
    logic                      r_valid, n_valid;

    // ray and per-sphere operands
    logic signed [XW-1:0]      r_ox, r_oy, r_oz, n_ox, n_oy, n_oz;
    logic signed [XW-1:0]      r_dx, r_dy, r_dz, n_dx, n_dy, n_dz;
    logic signed [XW-1:0]      r_near, n_near, r_far, n_far;
    logic                      r_unb, n_unb;
    logic signed [TW-1:0]      r_farv, n_farv;
    logic signed [rsn_pkg::CO_W-1:0] r_cox, r_coy, r_coz, n_cox, n_coy, n_coz;
    logic signed [XW-1:0]      r_rad, n_rad;
    logic [CW-1:0]             r_count, n_count, r_sph, n_sph, sph_next;

    // quadratic terms
    logic signed [PW-1:0]      r_acc, n_acc, acc_new;
    logic [rsn_pkg::DEN_W-1:0] r_a, n_a;
    logic signed [rsn_pkg::H_W-1:0] r_h, n_h;
    logic signed [rsn_pkg::K_W-1:0] r_k, n_k;
    logic [rsn_pkg::ROOT_W-1:0] r_s, n_s;
    logic                      r_root_sel, n_root_sel;
    logic                      r_num_neg, n_num_neg;

    // running best
    logic signed [TW-1:0]      r_best, n_best;
    logic [IW-1:0]             r_best_idx, n_best_idx;
    logic                      r_found, n_found;

    // result registers
    logic                      r_hit, n_hit;
    logic [3:0]                r_hit_idx, n_hit_idx;
    logic [XW-1:0]             r_nt, n_nt;

    // datapath wiring
    rsn_pkg::t_step            sctl;
    logic signed [MW-1:0]      opa, opb;
    logic                      mul_start, mul_done;
    logic signed [PW-1:0]      mul_prod;
    logic                      it_start, it_done;
    rsn_pkg::t_itmode          it_mode;
    logic [rsn_pkg::ROOT_W-1:0] it_root;
    logic [DVW-1:0]            it_quot, dividend;
    logic signed [NW-1:0]      nh, num;
    logic [NW-1:0]             num_mag;
    logic                      big;
    logic [rsn_pkg::SAT_BIT:0] t_abs;
    logic signed [TW-1:0]      t_mag, t_root, near_ext;
    logic                      t_ok;
    logic                      ram_we, ram_re;
    logic [IW-1:0]             ram_waddr;
    logic [SW-1:0]             ram_rdata;
    rsn_pkg::t_sphere          wr_sph, rd_sph;

    assign wr_sph = '{rad: i_dir_x, cz: i_point_z, cy: i_point_y, cx: i_point_x};
    assign rd_sph = rsn_pkg::t_sphere'(ram_rdata);
    assign ram_waddr = IW'(i_entry_index);

    rsn_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SPHERES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_sph),
        .i_re    (ram_re),
        .i_raddr (r_sph[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    rsn_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (opa),
        .i_b     (opb),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    rsn_sqdiv #(
        .DVW (DVW)
    ) u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (it_start),
        .i_mode  (it_mode),
        .i_rad   (unsigned'(r_acc)),
        .i_num   (dividend),
        .i_den   (r_a),
        .o_done  (it_done),
        .o_root  (it_root),
        .o_quot  (it_quot)
    );

    // multiplier operand select for the current program step
    function automatic logic signed [MW-1:0] pick(input rsn_pkg::t_opnd sel,
            input logic signed [XW-1:0] dx, input logic signed [XW-1:0] dy,
            input logic signed [XW-1:0] dz,
            input logic signed [rsn_pkg::CO_W-1:0] cx,
            input logic signed [rsn_pkg::CO_W-1:0] cy,
            input logic signed [rsn_pkg::CO_W-1:0] cz,
            input logic signed [XW-1:0] rad, input logic [rsn_pkg::DEN_W-1:0] a,
            input logic signed [rsn_pkg::H_W-1:0] h,
            input logic signed [rsn_pkg::K_W-1:0] k);
        logic signed [MW-1:0] v;
        v = '0;
        unique case (sel)
            rsn_pkg::OPND_DX: v = MW'(dx);
            rsn_pkg::OPND_DY: v = MW'(dy);
            rsn_pkg::OPND_DZ: v = MW'(dz);
            rsn_pkg::OPND_CX: v = MW'(cx);
            rsn_pkg::OPND_CY: v = MW'(cy);
            rsn_pkg::OPND_CZ: v = MW'(cz);
            rsn_pkg::OPND_R:  v = MW'(rad);
            rsn_pkg::OPND_A:  v = signed'(MW'(a));
            rsn_pkg::OPND_H:  v = MW'(h);
            rsn_pkg::OPND_K:  v = MW'(k);
            default: ;
        endcase
        return v;
    endfunction

    always_comb begin
        sctl = rsn_pkg::step_ctl(r_step);
        opa  = pick(sctl.a_sel, r_dx, r_dy, r_dz, r_cox, r_coy, r_coz, r_rad, r_a, r_h, r_k);
        opb  = pick(sctl.b_sel, r_dx, r_dy, r_dz, r_cox, r_coy, r_coz, r_rad, r_a, r_h, r_k);

        unique case (sctl.acc)
            rsn_pkg::ACC_SET: acc_new = mul_prod;
            rsn_pkg::ACC_ADD: acc_new = r_acc + mul_prod;
            rsn_pkg::ACC_SUB: acc_new = r_acc - mul_prod;
            default:          acc_new = mul_prod;
        endcase

        // numerator -H +/- S; larger root first
        nh       = -NW'(r_h);
        num      = r_root_sel ? (nh - signed'(NW'(r_s))) : (nh + signed'(NW'(r_s)));
        num_mag  = num[NW-1] ? unsigned'(-num) : unsigned'(num);
        dividend = {num_mag, {FRAC_BITS{1'b0}}};

        // quotient to a saturated signed root and bounds test
        big      = |it_quot[DVW-1:rsn_pkg::SAT_BIT];
        t_abs    = big ? rsn_pkg::T_SAT_MAG : {1'b0, it_quot[rsn_pkg::SAT_BIT-1:0]};
        t_mag    = signed'(TW'(t_abs));
        t_root   = r_num_neg ? -t_mag : t_mag;
        near_ext = TW'(r_near);
        t_ok     = (near_ext < t_root) && (t_root < r_farv) && (t_root < r_best);

        sph_next = r_sph + 1'b1;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_valid    = 1'b0;
        n_ox = r_ox; n_oy = r_oy; n_oz = r_oz;
        n_dx = r_dx; n_dy = r_dy; n_dz = r_dz;
        n_near     = r_near;
        n_far      = r_far;
        n_unb      = r_unb;
        n_farv     = r_farv;
        n_cox = r_cox; n_coy = r_coy; n_coz = r_coz;
        n_rad      = r_rad;
        n_count    = r_count;
        n_sph      = r_sph;
        n_acc      = r_acc;
        n_a        = r_a;
        n_h        = r_h;
        n_k        = r_k;
        n_s        = r_s;
        n_root_sel = r_root_sel;
        n_num_neg  = r_num_neg;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_found    = r_found;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_nt       = r_nt;
        mul_start  = 1'b0;
        it_start   = 1'b0;
        it_mode    = rsn_pkg::IT_SQRT;
        ram_we     = 1'b0;
        ram_re     = 1'b0;

        unique case (r_state)
            rsn_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_opcode == rsn_pkg::OPC_WRITE) begin
                        // out-of-table entries are dropped
                        ram_we = (32'(i_entry_index) < MAX_SPHERES);
                    end else begin
                        n_ox = i_point_x; n_oy = i_point_y; n_oz = i_point_z;
                        n_dx = i_dir_x;   n_dy = i_dir_y;   n_dz = i_dir_z;
                        n_near  = i_near_bound;
                        n_far   = i_far_bound;
                        n_unb   = i_far_unbounded;
                        n_farv  = i_far_unbounded ? rsn_pkg::T_UNBOUNDED : TW'(i_far_bound);
                        n_best  = n_farv;
                        n_best_idx = '0;
                        n_found = 1'b0;
                        n_sph   = '0;
                        n_count = (32'(r_active) > MAX_SPHERES) ? CW'(MAX_SPHERES)
                                                                 : CW'(r_active);
                        n_step  = rsn_pkg::MS_A_DX;
                        n_state = rsn_pkg::ST_MU_GO;
                    end
                end
            end
            rsn_pkg::ST_MU_GO: begin
                mul_start = 1'b1;
                n_state   = rsn_pkg::ST_MU_WT;
            end
            rsn_pkg::ST_MU_WT: begin
                if (mul_done) begin
                    n_acc = acc_new;
                    unique case (sctl.dst)
                        rsn_pkg::DST_A: n_a = acc_new[rsn_pkg::DEN_W-1:0];
                        rsn_pkg::DST_H: n_h = acc_new[rsn_pkg::H_W-1:0];
                        rsn_pkg::DST_K: n_k = acc_new[rsn_pkg::K_W-1:0];
                        default: ;
                    endcase
                    if (r_step == rsn_pkg::MS_A_DZ) begin
                        // zero direction or no spheres: nothing can hit
                        if (acc_new[rsn_pkg::DEN_W-1:0] == '0 || r_count == '0) begin
                            n_state = rsn_pkg::ST_DONE;
                        end else begin
                            n_state = rsn_pkg::ST_RD;
                        end
                    end else if (r_step == rsn_pkg::MS_Q_AK) begin
                        if (acc_new[PW-1]) begin
                            n_sph   = sph_next;
                            n_state = (sph_next == r_count) ? rsn_pkg::ST_DONE
                                                            : rsn_pkg::ST_RD;
                        end else begin
                            n_state = rsn_pkg::ST_SQ_GO;
                        end
                    end else begin
                        n_step  = rsn_pkg::t_mstep'(r_step + 1'b1);
                        n_state = rsn_pkg::ST_MU_GO;
                    end
                end
            end
            rsn_pkg::ST_RD: begin
                ram_re  = 1'b1;
                n_state = rsn_pkg::ST_CO;
            end
            rsn_pkg::ST_CO: begin
                n_cox   = rsn_pkg::CO_W'(r_ox) - rsn_pkg::CO_W'(rd_sph.cx);
                n_coy   = rsn_pkg::CO_W'(r_oy) - rsn_pkg::CO_W'(rd_sph.cy);
                n_coz   = rsn_pkg::CO_W'(r_oz) - rsn_pkg::CO_W'(rd_sph.cz);
                n_rad   = rd_sph.rad;
                n_step  = rsn_pkg::MS_H_X;
                n_state = rsn_pkg::ST_MU_GO;
            end
            rsn_pkg::ST_SQ_GO: begin
                it_start = 1'b1;
                it_mode  = rsn_pkg::IT_SQRT;
                n_state  = rsn_pkg::ST_SQ_WT;
            end
            rsn_pkg::ST_SQ_WT: begin
                if (it_done) begin
                    n_s        = it_root;
                    n_root_sel = 1'b0;
                    n_state    = rsn_pkg::ST_DV_GO;
                end
            end
            rsn_pkg::ST_DV_GO: begin
                it_start  = 1'b1;
                it_mode   = rsn_pkg::IT_DIV;
                n_num_neg = num[NW-1];
                n_state   = rsn_pkg::ST_DV_WT;
            end
            rsn_pkg::ST_DV_WT: begin
                it_mode = rsn_pkg::IT_DIV;
                if (it_done) begin
                    // strict compare against best keeps the earlier sphere on ties
                    if (t_ok) begin
                        n_best     = t_root;
                        n_best_idx = r_sph[IW-1:0];
                        n_found    = 1'b1;
                    end
                    if (!r_root_sel) begin
                        n_root_sel = 1'b1;
                        n_state    = rsn_pkg::ST_DV_GO;
                    end else begin
                        n_sph   = sph_next;
                        n_state = (sph_next == r_count) ? rsn_pkg::ST_DONE
                                                        : rsn_pkg::ST_RD;
                    end
                end
            end
            rsn_pkg::ST_DONE: begin
                n_valid   = 1'b1;
                n_hit     = r_found;
                n_hit_idx = r_found ? 4'(r_best_idx) : 4'd0;
                n_nt      = r_found ? r_best[XW-1:0]
                                    : (r_unb ? rsn_pkg::T_NOHIT_UNB : r_far);
                n_state   = rsn_pkg::ST_IDLE;
            end
            default: n_state = rsn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rsn_pkg::ST_IDLE;
            r_valid  <= 1'b0;
            r_active <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_ox <= n_ox; r_oy <= n_oy; r_oz <= n_oz;
        r_dx <= n_dx; r_dy <= n_dy; r_dz <= n_dz;
        r_near     <= n_near;
        r_far      <= n_far;
        r_unb      <= n_unb;
        r_farv     <= n_farv;
        r_cox <= n_cox; r_coy <= n_coy; r_coz <= n_coz;
        r_rad      <= n_rad;
        r_count    <= n_count;
        r_sph      <= n_sph;
        r_acc      <= n_acc;
        r_a        <= n_a;
        r_h        <= n_h;
        r_k        <= n_k;
        r_s        <= n_s;
        r_root_sel <= n_root_sel;
        r_num_neg  <= n_num_neg;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_found    <= n_found;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_nt       <= n_nt;
    end

    assign busy        = (r_state != rsn_pkg::ST_IDLE);
    assign o_valid     = r_valid;
    assign o_hit       = r_hit;
    assign o_hit_index = r_hit_idx;
    assign o_nearest_t = signed'(r_nt);

endmodule

/* hw/rtl/rsn_checker.sv */
// Port-level checks of the ray/sphere nearest-hit block, bound to the top.
// Depends on rsn_pkg and ray_sphere_nearest_hit.
module rsn_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_opcode,
    input logic       o_valid,
    input logic       o_hit,
    input logic [3:0] o_hit_index
);

    // a result only follows a cast in progress
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a cast in progress");

    // one result per cast, a single-cycle strobe
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_index == 4'd0))
        else $error("miss reported with nonzero index");

    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == rsn_pkg::OPC_CAST) |=> busy)
        else $error("cast transfer did not start work");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == rsn_pkg::OPC_WRITE) |=> (!busy && !o_valid))
        else $error("table write disturbed the sequencer");

endmodule

bind ray_sphere_nearest_hit rsn_props u_rsn_props (.*);

/* bench/rsn_checker.sv */
// Scoreboard for ray_sphere_nearest_hit: watches transfers, predicts hits, compares results.
// Depends on rsn_pkg for the opcode constants and T_NOHIT_UNB.
module rsn_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    input  logic               start,
    input  logic               busy,
    input  logic               i_opcode,
    input  logic [3:0]         i_entry_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic signed [31:0] i_near_bound,
    input  logic signed [31:0] i_far_bound,
    input  logic               i_far_unbounded,
    input  logic               o_valid,
    input  logic               o_hit,
    input  logic [3:0]         o_hit_index,
    input  logic signed [31:0] o_nearest_t,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_casts,
    output int                 o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [191:0] t_wide;

    typedef struct {
        logic        hit;
        logic [3:0]  idx;
        logic [31:0] t;
    } t_hit_rec;

    typedef struct {
        logic signed [31:0] cx, cy, cz, rad;
    } t_ball;

    t_ball      balls[16];
    logic [4:0] n_active;
    t_hit_rec   hits_due[$];

    function automatic t_wide isqrt_w(input t_wide x);
        t_wide r, c;
        r = '0;
        for (int k = 70; k >= 0; k--) begin
            c = r | (t_wide'(1) << k);
            if ($unsigned(c * c) <= $unsigned(x)) r = c;
        end
        return r;
    endfunction

    // trunc(num * 2^16 / den), clamped to +/-2^33
    function automatic logic signed [63:0] root_t(input t_wide num, input t_wide den);
        t_wide mag, q;
        logic signed [63:0] m;
        mag = (num < 0) ? -num : num;
        q = t_wide'($unsigned(mag << 16) / $unsigned(den));
        m = (q >= (t_wide'(1) << 33)) ? (64'sd1 <<< 33) : q[63:0];
        return (num < 0) ? -m : m;
    endfunction

    function automatic t_hit_rec predict_cast();
        t_hit_rec r;
        t_wide ox, oy, oz, dx, dy, dz, ux, uy, uz, rr, a, h, k, q, s;
        logic signed [63:0] nearv, farv, best, tr[2];
        int cnt;
        ox = t_wide'(i_point_x); oy = t_wide'(i_point_y); oz = t_wide'(i_point_z);
        dx = t_wide'(i_dir_x);   dy = t_wide'(i_dir_y);   dz = t_wide'(i_dir_z);
        nearv = 64'(i_near_bound);
        farv  = i_far_unbounded ? (64'sd1 <<< 31) : 64'(i_far_bound);
        best  = farv;
        r = '{hit: 1'b0, idx: 4'd0, t: 32'd0};
        cnt = (n_active > 16) ? 16 : int'(n_active);
        a = dx * dx + dy * dy + dz * dz;
        for (int n = 0; n < cnt; n++) begin
            if (a == 0) continue;
            ux = ox - t_wide'(balls[n].cx);
            uy = oy - t_wide'(balls[n].cy);
            uz = oz - t_wide'(balls[n].cz);
            rr = t_wide'(balls[n].rad);
            h = ux * dx + uy * dy + uz * dz;
            k = ux * ux + uy * uy + uz * uz - rr * rr;
            q = h * h - a * k;
            if (q < 0) continue;
            s = isqrt_w(q);
            tr[0] = root_t(-h + s, a);   // far root first
            tr[1] = root_t(-h - s, a);
            for (int j = 0; j < 2; j++)
                if (nearv < tr[j] && tr[j] < farv && tr[j] < best) begin
                    best  = tr[j];
                    r.hit = 1'b1;
                    r.idx = n[3:0];
                end
        end
        if (r.hit) r.t = best[31:0];
        else       r.t = i_far_unbounded ? rsn_pkg::T_NOHIT_UNB : i_far_bound;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_hit_rec w;
        if (!i_rst_n) begin
            n_active = '0;
            foreach (balls[i]) balls[i] = '{0, 0, 0, 0};
            hits_due.delete();
            o_errors = 0; o_casts = 0; o_hits = 0;
        end else begin
            if (o_valid) begin
                if (hits_due.size() == 0) begin
                    report_mismatch("unexpected result", o_nearest_t, 0);
                end else begin
                    w = hits_due.pop_front();
                    if (o_hit !== w.hit)
                        report_mismatch("hit", 32'(o_hit), 32'(w.hit));
                    if (o_hit_index !== w.idx)
                        report_mismatch("index", 32'(o_hit_index), 32'(w.idx));
                    if (o_nearest_t !== w.t)     report_mismatch("t", o_nearest_t, w.t);
                end
            end
            if (i_cfg_we) n_active = i_cfg_wdata;
            if (start && !busy) begin
                if (i_opcode == rsn_pkg::OPC_WRITE) begin
                    balls[i_entry_index] = '{i_point_x, i_point_y, i_point_z, i_dir_x};
                end else begin
                    w = predict_cast();
                    hits_due = {hits_due, w};
                    o_casts++;
                    if (w.hit) o_hits++;
                end
            end
        end
        o_pending = hits_due.size();
    end
endmodule

/* bench/tb_top.sv */
// Stimulus and verdict for ray_sphere_nearest_hit; rsn_checker does the scoring.
// Depends on rsn_pkg, the block RTL and bench/rsn_checker.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk, i_rst_n, i_cfg_we, start, busy;
    logic [4:0]         i_cfg_wdata;
    logic               i_opcode, i_far_unbounded;
    logic [3:0]         i_entry_index;
    logic signed [31:0] i_point_x, i_point_y, i_point_z;
    logic signed [31:0] i_dir_x, i_dir_y, i_dir_z, i_near_bound, i_far_bound;
    logic               o_valid, o_hit;
    logic [3:0]         o_hit_index;
    logic signed [31:0] o_nearest_t;
    int                 errors, pending, casts, hits;
    bit                 calm;      // no idle cycles while set

    localparam logic signed [31:0] ONE = 32'sh0001_0000;   // 1.0 in Q16.16

    ray_sphere_nearest_hit dut (.*);

    rsn_checker chk (
        .*,
        .o_errors(errors), .o_pending(pending), .o_casts(casts), .o_hits(hits)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #40ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

    // One transfer: inputs go out at the falling edge, acceptance is seen at a
    // rising edge with busy low. start stays high into the next item.
    task automatic send(input logic op, input int idx,
                        input logic [31:0] px, py, pz, dx, dy, dz, nb, fb,
                        input int unb);
        if (!calm && $urandom_range(99) < 31) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op; i_entry_index <= idx[3:0];
        i_point_x <= px; i_point_y <= py; i_point_z <= pz;
        i_dir_x <= dx; i_dir_y <= dy; i_dir_z <= dz;
        i_near_bound <= nb; i_far_bound <= fb; i_far_unbounded <= unb[0];
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Register write only once everything in flight has drained.
    task automatic set_active(input int n);
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_wdata <= n[4:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] small_q(input int span);
        return $signed($urandom_range(2 * span * 65536)) - span * 65536;
    endfunction

    // Random transfer: mostly sphere writes or rays aimed near a sphere,
    // some full-range noise.
    task automatic random_item();
        logic [31:0] cx, cy, cz, ox, oy, oz, nb, fb;
        int r, sh;
        r = $urandom_range(99);
        if (r < 10) begin
            send(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom_range(1));
        end else if (r < 45) begin
            send(rsn_pkg::OPC_WRITE, $urandom, small_q(8), small_q(8), small_q(8),
                 $urandom_range(1, 4 * 65536) * (($urandom_range(7) == 0) ? -1 : 1),
                 $urandom, $urandom, $urandom, $urandom, $urandom_range(1));
        end else begin
            cx = small_q(8); cy = small_q(8); cz = small_q(8);
            ox = small_q(16); oy = small_q(16); oz = small_q(16);
            sh = $urandom_range(0, 4);
            nb = ($urandom_range(3) == 0) ? -small_q(4) : 32'd0;
            fb = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 64) * 65536;
            send(rsn_pkg::OPC_CAST, $urandom, ox, oy, oz,
                 (($signed(cx) - $signed(ox)) >>> sh) + small_q(1),
                 (($signed(cy) - $signed(oy)) >>> sh) + small_q(1),
                 (($signed(cz) - $signed(oz)) >>> sh) + small_q(1),
                 nb, fb, int'($urandom_range(3) == 0));
        end
    endtask

    initial begin
        int plan[8]  = '{1, 2, 3, 0, 4, 2, 16, 31};
        int count[8] = '{200, 190, 120, 110, 110, 150, 15, 10};
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0; start = 1'b0;
        i_opcode = rsn_pkg::OPC_WRITE; i_entry_index = '0; i_far_unbounded = 1'b0;
        i_point_x = '0; i_point_y = '0; i_point_z = '0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0; i_near_bound = '0; i_far_bound = '0;
        calm = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the whole table so no cast ever reads an unwritten entry.
        // Entries 0 and 1 are identical to force a tie; 2 is tangent to the x axis;
        // 3 has a negative radius; 15 sits at the extremes.
        send(rsn_pkg::OPC_WRITE, 0, 10 * ONE, 0, 0, 2 * ONE, 0, 0, 0, 0, 0);
        send(rsn_pkg::OPC_WRITE, 1, 10 * ONE, 0, 0, 2 * ONE, 0, 0, 0, 0, 0);
        send(rsn_pkg::OPC_WRITE, 2, 5 * ONE, ONE, 0, ONE, 0, 0, 0, 0, 0);
        send(rsn_pkg::OPC_WRITE, 3, 0, 0, 20 * ONE, -3 * ONE, 0, 0, 0, 0, 0);
        for (int e = 4; e < 15; e++)
            send(rsn_pkg::OPC_WRITE, e, small_q(30), small_q(30), small_q(30),
                 $urandom_range(1, 5 * 65536), 0, 0, 0, 0, 0);
        send(rsn_pkg::OPC_WRITE, 15, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
             32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
        set_active(16);
        // tie on the x axis, bounded far
        send(rsn_pkg::OPC_CAST, 0, 0, 0, 0, ONE, 0, 0, 0, 100 * ONE, 0);
        // ray along the y = 1 line through the center of sphere 2, unbounded far
        send(rsn_pkg::OPC_CAST, 0, 0, ONE, 0, ONE, 0, 0, 0, 0, 1);
        // zero direction: no roots anywhere
        send(rsn_pkg::OPC_CAST, 0, ONE, ONE, ONE, 0, 0, 0, -ONE, 5 * ONE, 0);
        // negative discriminant everywhere likely, far small
        send(rsn_pkg::OPC_CAST, 0, 0, 50 * ONE, 0, 0, 0, ONE, 0, ONE, 0);
        // tiny direction: huge roots saturate
        send(rsn_pkg::OPC_CAST, 0, 0, 0, 0, 1, 0, 0, 32'h80000000, 32'h7FFFFFFF, 1);
        // extremes of every field
        send(rsn_pkg::OPC_CAST, 15, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
             32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
        // negative radius sphere along z, near beyond the first root
        send(rsn_pkg::OPC_CAST, 0, 0, 0, 0, 0, 0, ONE, 18 * ONE, 32'h7FFFFFFF, 0);
        set_active(0);
        send(rsn_pkg::OPC_CAST, 0, 0, 0, 0, ONE, 0, 0, 0, 9 * ONE, 0);
        send(rsn_pkg::OPC_CAST, 0, 0, 0, 0, ONE, 0, 0, 0, 0, 1);

        for (int p = 0; p < 8; p++) begin
            set_active(plan[p]);
            calm = (p == 2);
            for (int i = 0; i < count[p]; i++) random_item();
        end
        calm = 1'b0;
        start <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("%0d rays cast, %0d hits, active counts from 0 to 31", casts, hits);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
